>>> design/pwmfd_pkg.sv
// ----------------------------------------------------------------------------
// pwmfd_pkg: shared types and constants
// Item structs, controller/datapath command and status bundles, and frame
// limits for the pulse width Manchester frame decoder.
// ----------------------------------------------------------------------------
package pwmfd_pkg;

    localparam int MaxHalfBits = 78;
    localparam int FrameBits   = 32;
    localparam int MaxSymbols  = 128;

    localparam logic [1:0] StatusOk       = 2'd0;
    localparam logic [1:0] StatusBadCount = 2'd1;
    localparam logic [1:0] StatusOddPar   = 2'd2;

    typedef struct packed {
        logic [14:0] first_duration;
        logic        first_level;
        logic [14:0] second_duration;
        logic        second_level;
        logic        last_symbol;
    } pwmfd_in_t;

    typedef struct packed {
        logic [31:0] frame_word;
        logic [1:0]  decode_status;
    } pwmfd_out_t;

    typedef struct packed {
        logic capture;
        logic take_half;
        logic part_sel;
        logic clr_idx;
        logic finish;
    } pwmfd_cmd_t;

    typedef struct packed {
        logic part_done;
        logic last;
        logic out_free;
    } pwmfd_stat_t;

endpackage

>>> design/pwmfd_ctrl.sv
// ----------------------------------------------------------------------------
// pwmfd_ctrl: symbol sequencer
// Steps through the two parts of a captured symbol one half-bit a cycle and
// closes the frame on the last symbol.
// ----------------------------------------------------------------------------
module pwmfd_ctrl
    import pwmfd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  pwmfd_stat_t stat,
    output pwmfd_cmd_t  cmd
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_PART0 = 4'b0010,
        ST_PART1 = 4'b0100,
        ST_FIN   = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_PART0;
                end
            end
            ST_PART0: begin
                cmd.take_half = 1'b1;
                cmd.part_sel  = 1'b0;
                if (stat.part_done) begin
                    cmd.clr_idx = 1'b1;
                    state_next  = ST_PART1;
                end
            end
            ST_PART1: begin
                cmd.take_half = 1'b1;
                cmd.part_sel  = 1'b1;
                if (stat.part_done) begin
                    cmd.clr_idx = 1'b1;
                    state_next  = ST_FIN;
                end
            end
            ST_FIN: begin
                // on a last symbol, hold until the result register can take the frame
                if (!stat.last) begin
                    state_next = ST_IDLE;
                end else if (stat.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> design/pwmfd_dpath.sv
// ----------------------------------------------------------------------------
// pwmfd_dpath: decoder datapath
// Symbol capture, half-bit pairing, frame shift register, status check and
// the result register.
// ----------------------------------------------------------------------------
module pwmfd_dpath
    import pwmfd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  pwmfd_in_t   s_data,
    input  pwmfd_cmd_t  cmd,
    output pwmfd_stat_t stat,
    output logic        m_valid,
    input  logic        m_ready,
    output pwmfd_out_t  m_data
);

    // half-bits in one part of the given duration
    function automatic logic [2:0] halves_for(input logic [14:0] d);
        logic [2:0] n;
        if (d >= 15'd350 && d <= 15'd650) begin
            n = 3'd1;
        end else if (d >= 15'd850 && d <= 15'd1150) begin
            n = 3'd2;
        end else if (d < 15'd750) begin
            n = 3'd1;
        end else if (d < 15'd1250) begin
            n = 3'd2;
        end else if (d < 15'd1750) begin
            n = 3'd3;
        end else begin
            n = 3'd4;
        end
        return n;
    endfunction

    pwmfd_in_t   sym_reg;
    logic        active_reg, active_next;
    logic [2:0]  idx_reg, idx_next;
    logic [6:0]  hb_reg, hb_next;
    logic        pend_reg, pend_next;
    logic        start_reg, start_next;
    logic [31:0] shift_reg, shift_next;
    logic [5:0]  dbc_reg, dbc_next;
    logic [7:0]  sym_cnt_reg, sym_cnt_next;
    logic        m_valid_reg, m_valid_next;
    pwmfd_out_t  m_data_reg, m_data_next;

    logic [14:0] dur;
    logic        lvl;
    logic        part_act;
    logic [2:0]  n_halves;
    logic [1:0]  status;

    assign dur      = cmd.part_sel ? sym_reg.second_duration : sym_reg.first_duration;
    assign lvl      = cmd.part_sel ? sym_reg.second_level : sym_reg.first_level;
    assign part_act = active_reg && (dur != 15'd0);
    assign n_halves = halves_for(dur);

    assign stat.part_done = !part_act || ((idx_reg + 3'd1) == n_halves);
    assign stat.last      = sym_reg.last_symbol;
    assign stat.out_free  = !m_valid_reg || m_ready;

    always_comb begin
        if (dbc_reg != 6'(FrameBits)) begin
            status = StatusBadCount;
        end else if (^shift_reg) begin
            status = StatusOddPar;
        end else begin
            status = StatusOk;
        end
    end

    always_comb begin
        active_next  = active_reg;
        idx_next     = idx_reg;
        hb_next      = hb_reg;
        pend_next    = pend_reg;
        start_next   = start_reg;
        shift_next   = shift_reg;
        dbc_next     = dbc_reg;
        sym_cnt_next = sym_cnt_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;

        if (cmd.capture) begin
            // symbols past the limit still close the frame but add nothing
            active_next = (sym_cnt_reg < 8'(MaxSymbols));
            if (sym_cnt_reg < 8'(MaxSymbols)) begin
                sym_cnt_next = sym_cnt_reg + 8'd1;
            end
            idx_next = 3'd0;
        end

        if (cmd.take_half) begin
            idx_next = idx_reg + 3'd1;
            if (part_act && (hb_reg < 7'(MaxHalfBits))) begin
                hb_next = hb_reg + 7'd1;
                if (!hb_reg[0]) begin
                    pend_next = lvl;
                end else if ((dbc_reg < 6'(FrameBits)) && (pend_reg != lvl)) begin
                    if (!start_reg) begin
                        start_next = pend_reg;
                    end else begin
                        shift_next = {shift_reg[30:0], pend_reg};
                        dbc_next   = dbc_reg + 6'd1;
                    end
                end
            end
        end

        if (cmd.clr_idx) begin
            idx_next = 3'd0;
        end

        if (cmd.finish) begin
            m_valid_next             = 1'b1;
            m_data_next.decode_status = status;
            m_data_next.frame_word   = (status == StatusOk) ? shift_reg : 32'd0;
            // clear for the next frame
            hb_next      = 7'd0;
            pend_next    = 1'b0;
            start_next   = 1'b0;
            shift_next   = 32'd0;
            dbc_next     = 6'd0;
            sym_cnt_next = 8'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            sym_reg <= s_data;
        end
        m_data_reg <= m_data_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg  <= 1'b0;
            idx_reg     <= 3'd0;
            hb_reg      <= 7'd0;
            pend_reg    <= 1'b0;
            start_reg   <= 1'b0;
            shift_reg   <= 32'd0;
            dbc_reg     <= 6'd0;
            sym_cnt_reg <= 8'd0;
            m_valid_reg <= 1'b0;
        end else begin
            active_reg  <= active_next;
            idx_reg     <= idx_next;
            hb_reg      <= hb_next;
            pend_reg    <= pend_next;
            start_reg   <= start_next;
            shift_reg   <= shift_next;
            dbc_reg     <= dbc_next;
            sym_cnt_reg <= sym_cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

>>> design/pulse_width_manchester_frame_decoder_core.sv
// ----------------------------------------------------------------------------
// pulse_width_manchester_frame_decoder_core: Manchester frame decoder
// Turns captured pulse symbols into a start-bit aligned data frame with a
// bit count and parity status.
// ----------------------------------------------------------------------------
// Each input item is one pulse symbol of two level/duration parts. Every part
// of non-zero duration expands to one to four half-bits, which are paired
// into Manchester bits (10 is a one, 01 a zero, other pairs dropped); the
// first one is the start bit and the next FrameBits bits are shifted in MSB
// first. On a symbol marked last, one result item carries the frame word and
// its status (ok, wrong bit count, odd parity); the word reads zero unless
// the status is ok, and all frame state then clears. A symbol is captured,
// then its first part and its second part are walked, an empty part passing
// through too, and a closing step follows: the sequencer feeds one half-bit
// a cycle through the pairing logic. A last symbol waits in its closing step
// while the result register still holds an untaken item; otherwise the next
// item is taken while a result waits.
// ----------------------------------------------------------------------------
module pulse_width_manchester_frame_decoder_core
    import pwmfd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  pwmfd_in_t  s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output pwmfd_out_t m_data
);

    // command and status bundles between sequencer and datapath
    pwmfd_cmd_t  cmd;
    pwmfd_stat_t stat;

    // sequencer: accept a symbol, walk its two parts, close the frame
    pwmfd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // datapath: pairing, shifting, status and the result register
    pwmfd_dpath u_dpath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .stat    (stat),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

>>> tb/sv/pulse_width_manchester_frame_decoder_core_tb.sv
// ----------------------------------------------------------------------------
// pulse_width_manchester_frame_decoder_core_tb: self-checking frame decoder test
// Drives pulse symbol items through the valid/ready input channel. A local
// Manchester decoder predicts every frame result, and each result item taken
// from the output channel is checked against it field by field. Stimulus is
// a short directed set, then mostly well-formed frames with random content
// mixed with truncated, spoilt, noisy and over-long frames. Both sides idle
// at random.
// ----------------------------------------------------------------------------
module pulse_width_manchester_frame_decoder_core_tb;
    import pwmfd_pkg::*;

    localparam int ClkHalf     = 6;
    localparam int ResetCycles = 6;
    localparam int RandomItems = 1950;
    localparam int MaxCycles   = 1_000_000;
    localparam int TailCycles  = 30;
    localparam int ReportLimit = 10;

    // One symbol waiting to be driven, with the idle cycles to insert ahead
    // of it and whether to hold it back until every frame result has arrived.
    typedef struct {
        pwmfd_in_t sym;
        int        gap;
        bit        drain;
    } pending_sym_t;

    logic       aclk    = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    pwmfd_in_t  s_data  = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    pwmfd_out_t m_data;

    pending_sym_t pending_q[$];
    pwmfd_out_t   frame_q[$];

    // Counters of frame results: due is bumped by the driver when a last
    // symbol is taken, got by the monitor when a result item is taken.
    // Both move by nonblocking assignment so that either side reads a stable
    // value at the clock edge.
    int results_due = 0;
    int results_got = 0;
    int syms_taken  = 0;
    int fail_count  = 0;
    int n_clean     = 0;
    int n_bad_count = 0;
    int n_odd_par   = 0;

    // Predictor state for the frame being received.
    int          half_count  = 0;
    logic        held_level  = 1'b0;
    bit          start_found = 1'b0;
    logic [31:0] frame_acc   = '0;
    int          data_bits   = 0;
    int          sym_count   = 0;

    // Receiver idling state.
    int rx_stall     = 0;
    int rx_mode_left = 0;
    bit rx_quiet     = 1'b0;

    pulse_width_manchester_frame_decoder_core u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #ClkHalf aclk = 1'b1;
        #ClkHalf aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Half-bits for one part: the two nominal windows first, else round to
    // the nearest 500 ticks and clamp to one..four.
    function automatic int halves_of(logic [14:0] dur);
        int n;
        if (dur >= 350 && dur <= 650) return 1;
        if (dur >= 850 && dur <= 1150) return 2;
        n = (int'(dur) + 250) / 500;
        if (n < 1) n = 1;
        if (n > 4) n = 4;
        return n;
    endfunction

    // Feed one half-bit into the pairing logic.
    task automatic push_half(logic lvl);
        logic first;
        // Drop anything past the half-bit budget.
        if (half_count >= MaxHalfBits) return;
        if (half_count % 2 == 0) begin
            held_level = lvl;
            half_count++;
            return;
        end
        half_count++;
        first = held_level;
        // Ignore pairs once the frame is full, and skip 00 and 11.
        if (data_bits >= FrameBits) return;
        if (first == lvl) return;
        if (!start_found) begin
            if (first) start_found = 1'b1;
            return;
        end
        frame_acc = {frame_acc[30:0], first};
        data_bits++;
    endtask

    // Advance the predicted state by one symbol; on a last symbol, queue the
    // frame result and clear for the next frame.
    task automatic decode_symbol(pwmfd_in_t sym);
        pwmfd_out_t res;
        int         n;
        if (sym_count < MaxSymbols) begin
            sym_count++;
            if (sym.first_duration != 0) begin
                n = halves_of(sym.first_duration);
                repeat (n) push_half(sym.first_level);
            end
            if (sym.second_duration != 0) begin
                n = halves_of(sym.second_duration);
                repeat (n) push_half(sym.second_level);
            end
        end
        if (sym.last_symbol) begin
            if (data_bits != FrameBits) res.decode_status = StatusBadCount;
            else if (^frame_acc) res.decode_status = StatusOddPar;
            else res.decode_status = StatusOk;
            res.frame_word = (res.decode_status == StatusOk) ? frame_acc : '0;
            frame_q.push_back(res);
            half_count  = 0;
            held_level  = 1'b0;
            start_found = 1'b0;
            frame_acc   = '0;
            data_bits   = 0;
            sym_count   = 0;
        end
    endtask

    task automatic flag(string what, longint exp_val, longint got_val);
        if (fail_count < ReportLimit)
            $display("mismatch: %s: expected %0h, actual %0h", what, exp_val, got_val);
        fail_count++;
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic pwmfd_in_t make_sym(logic [14:0] d0, logic l0,
                                           logic [14:0] d1, logic l1, logic last);
        pwmfd_in_t sym;
        sym.first_duration  = d0;
        sym.first_level     = l0;
        sym.second_duration = d1;
        sym.second_level    = l1;
        sym.last_symbol     = last;
        return sym;
    endfunction

    // Idle length: mostly short, now and then long.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Duration for a run of one or two equal half-bits: mostly inside the
    // nominal window, sometimes on its edges, sometimes anywhere that still
    // rounds to the same count.
    function automatic logic [14:0] run_dur(int len);
        int r;
        r = $urandom_range(0, 99);
        if (len == 1) begin
            if (r < 70) return 15'($urandom_range(350, 650));
            if (r < 80) return (r % 2) ? 15'd350 : 15'd650;
            return 15'($urandom_range(1, 749));
        end
        if (r < 70) return 15'($urandom_range(850, 1150));
        if (r < 80) return (r % 2) ? 15'd850 : 15'd1150;
        return 15'($urandom_range(750, 1249));
    endfunction

    task automatic push_item(pwmfd_in_t sym, bit gappy, bit drain);
        pending_sym_t ent;
        ent.sym   = sym;
        ent.gap   = (gappy && $urandom_range(0, 2) == 0) ? idle_len() : 0;
        ent.drain = drain;
        pending_q.push_back(ent);
    endtask

    // Random symbols, optionally closing the frame on the final one.
    task automatic queue_noise(int count, bit gappy, bit drain, bit close);
        pwmfd_in_t sym;
        int        i;
        for (i = 0; i < count; i++) begin
            sym = make_sym(0, 1'($urandom_range(0, 1)), 0, 1'($urandom_range(0, 1)),
                           close && i == count - 1);
            case ($urandom_range(0, 3))
                0, 1: begin
                    sym.first_duration  = 15'($urandom_range(0, 32767));
                    sym.second_duration = 15'($urandom_range(0, 32767));
                end
                2: begin
                    sym.first_duration  = 15'($urandom_range(0, 2500));
                    sym.second_duration = 15'($urandom_range(0, 2500));
                end
                default: ;
            endcase
            push_item(sym, gappy, drain && i == 0);
        end
    endtask

    // Encode a frame: lead zeros, start bit, the top nbits of word MSB first,
    // random tail bits. Merge equal half-bits into runs and pack the runs two
    // to a symbol, with the odd empty part thrown in.
    task automatic queue_frame(int lead, int nbits, logic [31:0] word, int tail,
                               int pad, bit gappy, bit drain, bit spoil);
        logic      hb[$];
        logic      run_lvl[$];
        int        run_len[$];
        pwmfd_in_t sym;
        int        first_idx;
        int        i;
        int        k;
        logic      b;
        first_idx = pending_q.size();
        repeat (lead) begin
            hb.push_back(1'b0);
            hb.push_back(1'b1);
        end
        hb.push_back(1'b1);
        hb.push_back(1'b0);
        for (i = 0; i < nbits; i++) begin
            hb.push_back(word[31 - i]);
            hb.push_back(!word[31 - i]);
        end
        repeat (tail) begin
            b = 1'($urandom_range(0, 1));
            hb.push_back(b);
            hb.push_back(!b);
        end
        for (i = 0; i < hb.size(); i++) begin
            if (run_lvl.size() > 0 && run_lvl[run_lvl.size() - 1] == hb[i])
                run_len[run_len.size() - 1]++;
            else begin
                run_lvl.push_back(hb[i]);
                run_len.push_back(1);
            end
        end
        repeat (pad) push_item(make_sym(0, 0, 0, 0, 0), gappy, 1'b0);
        k = 0;
        while (k < run_len.size()) begin
            sym = make_sym(0, 1'($urandom_range(0, 1)), 0, 1'($urandom_range(0, 1)), 0);
            if ($urandom_range(0, 9) != 0) begin
                sym.first_duration = run_dur(run_len[k]);
                sym.first_level    = run_lvl[k];
                k++;
            end
            if (k < run_len.size() && $urandom_range(0, 6) != 0) begin
                sym.second_duration = run_dur(run_len[k]);
                sym.second_level    = run_lvl[k];
                k++;
            end
            sym.last_symbol = (k >= run_len.size());
            push_item(sym, gappy, 1'b0);
        end
        pending_q[first_idx].drain = drain;
        if (spoil) begin
            k = $urandom_range(first_idx, pending_q.size() - 1);
            pending_q[k].sym.first_duration = 15'($urandom_range(0, 32767));
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: present the head of the pending queue, predict on acceptance
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        int  due_now;
        bit  took;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            took    = s_valid && s_ready;
            due_now = results_due;
            if (took) begin
                decode_symbol(s_data);
                syms_taken <= syms_taken + 1;
                if (s_data.last_symbol) begin
                    due_now = results_due + 1;
                    results_due <= due_now;
                end
            end
            // Hold the current item until it is taken; otherwise move on.
            if (!s_valid || took) begin
                if (pending_q.size() == 0) begin
                    s_valid <= 1'b0;
                end else if (pending_q[0].gap > 0) begin
                    pending_q[0].gap = pending_q[0].gap - 1;
                    s_valid <= 1'b0;
                end else if (pending_q[0].drain && results_got != due_now) begin
                    // Pause until every outstanding frame result has come.
                    s_valid <= 1'b0;
                end else begin
                    s_data  <= pending_q[0].sym;
                    s_valid <= 1'b1;
                    pending_q.pop_front();
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check each result item, then pick the next ready level
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        pwmfd_out_t exp_res;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (frame_q.size() == 0) begin
                    flag("result item with nothing expected", 0, m_data.frame_word);
                end else begin
                    exp_res = frame_q.pop_front();
                    results_got <= results_got + 1;
                    case (exp_res.decode_status)
                        StatusOk:       n_clean++;
                        StatusBadCount: n_bad_count++;
                        default:        n_odd_par++;
                    endcase
                    if (m_data.frame_word !== exp_res.frame_word)
                        flag("frame_word", exp_res.frame_word, m_data.frame_word);
                    if (m_data.decode_status !== exp_res.decode_status)
                        flag("decode_status", exp_res.decode_status, m_data.decode_status);
                end
            end
            // Alternate between stretches that never stall and stretches
            // with random stalls.
            if (rx_mode_left == 0) begin
                rx_quiet     = ($urandom_range(0, 3) == 0);
                rx_mode_left = $urandom_range(20, 400);
            end else begin
                rx_mode_left--;
            end
            if (rx_stall > 0) begin
                rx_stall--;
                m_ready <= 1'b0;
            end else if (!rx_quiet && $urandom_range(0, 3) == 0) begin
                rx_stall = idle_len() - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus, reset and end of run
    // ------------------------------------------------------------------
    initial begin
        int          kind;
        int          lead;
        int          tail;
        int          target;
        bit          gappy;
        bit          drain;
        bit          first_frame;
        logic [31:0] word;

        // Directed: field extremes and the awkward corners.
        // All-ones durations and both levels: pairs 11 and 00 only.
        push_item(make_sym(15'h7fff, 1, 15'h7fff, 0, 1), 0, 0);
        // Both parts absent: nothing decoded at all.
        push_item(make_sym(0, 0, 0, 1, 1), 0, 0);
        // Shortest durations form the start bit, then a zero, then 11 and 00.
        push_item(make_sym(1, 1, 1, 0, 0), 0, 0);
        push_item(make_sym(350, 0, 650, 1, 0), 0, 0);
        push_item(make_sym(849, 1, 850, 0, 1), 0, 0);
        // A lone unpaired half-bit closing the frame.
        push_item(make_sym(500, 1, 0, 0, 1), 0, 0);
        // Rounding edges either side of each half-bit count.
        push_item(make_sym(249, 0, 2249, 1, 0), 0, 0);
        push_item(make_sym(349, 1, 651, 0, 0), 0, 0);
        push_item(make_sym(749, 1, 750, 0, 0), 0, 0);
        push_item(make_sym(1249, 1, 1250, 0, 0), 0, 0);
        push_item(make_sym(1749, 0, 1750, 1, 0), 0, 0);
        push_item(make_sym(1150, 1, 1151, 0, 1), 0, 0);
        // Start bit then long equal runs that pair only as 11 and 00.
        push_item(make_sym(500, 1, 500, 0, 0), 0, 0);
        push_item(make_sym(32767, 1, 32767, 0, 0), 0, 0);
        push_item(make_sym(32767, 1, 32767, 0, 0), 0, 0);
        push_item(make_sym(16384, 0, 16383, 1, 1), 0, 0);

        // Random: mostly well-formed frames, the rest broken or noisy.
        target      = pending_q.size() + RandomItems;
        first_frame = 1'b1;
        while (pending_q.size() < target) begin
            kind  = $urandom_range(0, 99);
            gappy = ($urandom_range(0, 9) >= 3);
            drain = first_frame || ($urandom_range(0, 19) == 0);
            word  = $urandom;
            // Keep parity even most of the time so that clean frames dominate.
            if ($urandom_range(0, 4) != 0 && ^word) word[0] = !word[0];
            lead  = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 7) : 0;
            tail  = $urandom_range(0, 4);
            if (kind < 70)
                queue_frame(lead, FrameBits, word, tail, 0, gappy, drain, 0);
            else if (kind < 80)
                queue_frame(lead, $urandom_range(0, FrameBits - 1), word, tail, 0,
                            gappy, drain, 0);
            else if (kind < 90)
                queue_noise($urandom_range(1, 10), gappy, drain, 1);
            else if (kind < 95)
                queue_frame(lead, FrameBits, word, tail, 0, gappy, drain, 1);
            else if (kind < 97)
                // Pad with empty symbols so the frame may run past the symbol limit.
                queue_frame(0, FrameBits, word, tail, $urandom_range(90, 127),
                            gappy, drain, 0);
            else begin
                queue_noise($urandom_range(1, 4), gappy, drain, 0);
                queue_frame(lead, FrameBits, word, tail, 0, gappy, 0, 0);
            end
            first_frame = 1'b0;
        end

        repeat (ResetCycles) @(posedge aclk);
        aresetn <= 1'b1;

        // Drain: sample on the falling edge, clear of the clocked updates.
        while (pending_q.size() != 0 || s_valid || results_got != results_due)
            @(negedge aclk);
        repeat (TailCycles) @(posedge aclk);
        if (frame_q.size() != 0) flag("frame results never arrived", 0, frame_q.size());

        $display("covered %0d symbols in %0d frames: %0d clean, %0d bad bit count, %0d odd parity",
                 syms_taken, results_got, n_clean, n_bad_count, n_odd_par);
        if (fail_count == 0) begin
            $display("[pulse_width_manchester_frame_decoder_core] OK");
        end else begin
            $display("%0d mismatches in total", fail_count);
            $display("[pulse_width_manchester_frame_decoder_core] ERROR");
        end
        $finish;
    end

    // Watchdog: give up well past the slowest legal run.
    initial begin
        #(2 * ClkHalf * MaxCycles);
        $display("timeout after %0d cycles", MaxCycles);
        $display("[pulse_width_manchester_frame_decoder_core] ERROR");
        $finish;
    end

endmodule

>>> filelist.f
design/pwmfd_pkg.sv
design/pwmfd_ctrl.sv
design/pwmfd_dpath.sv
design/pulse_width_manchester_frame_decoder_core.sv
tb/sv/pulse_width_manchester_frame_decoder_core_tb.sv
